// ===== hdl/rpdq_pkg.sv =====
// Shared widths, types and group decode for the relative pose delta unit.
package rpdq_pkg;

  localparam int WordW  = 32;               // every stream field
  localparam int NumIn  = 12;               // fields of one input pose
  localparam int FracW  = 30;               // Q1.30 fraction bits
  localparam int OpW    = WordW + 1;        // multiplier operand, holds a translation difference
  localparam int AccW   = 2 * OpW;          // product and accumulator
  localparam int DW     = 37;               // one entry of the delta rotation
  localparam int VW     = 39;               // raw quaternion component
  localparam int MagW   = 31;               // scaled magnitude, below 2^31
  localparam int SqW    = 64;               // sum of squares
  localparam int RootW  = 32;               // quaternion norm
  localparam int QuoW   = 31;               // normalised component, at most 2^30

  typedef logic [3:0] tag_t;

  // Accumulator tags: groups 0..8 are delta rotation entries, 9..11 delta translation.
  localparam tag_t TagRotLast   = 4'd8;
  localparam tag_t TagTransBase = 4'd9;
  localparam tag_t TagLastGroup = 4'd11;
  localparam tag_t TagSumSq     = 4'd12;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic rnd;
    tag_t tag;
  } mac_op_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } mac_res_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic       trans;
  } grp_sel_t;

  // Decode a group into the previous-rotation column and the current operand.
  function automatic grp_sel_t grp_sel(input tag_t g);
    grp_sel_t s;
    s = '0;
    case (g)
      4'd0:  begin s.row = 2'd0; s.col = 2'd0; end
      4'd1:  begin s.row = 2'd0; s.col = 2'd1; end
      4'd2:  begin s.row = 2'd0; s.col = 2'd2; end
      4'd3:  begin s.row = 2'd1; s.col = 2'd0; end
      4'd4:  begin s.row = 2'd1; s.col = 2'd1; end
      4'd5:  begin s.row = 2'd1; s.col = 2'd2; end
      4'd6:  begin s.row = 2'd2; s.col = 2'd0; end
      4'd7:  begin s.row = 2'd2; s.col = 2'd1; end
      4'd8:  begin s.row = 2'd2; s.col = 2'd2; end
      4'd9:  begin s.row = 2'd0; s.trans = 1'b1; end
      4'd10: begin s.row = 2'd1; s.trans = 1'b1; end
      4'd11: begin s.row = 2'd2; s.trans = 1'b1; end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/rpdq_mac.sv =====
// Shared registered multiplier with rounding accumulator.
module rpdq_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpdq_pkg::mac_op_t                   op_i,
  input  logic signed [rpdq_pkg::OpW-1:0]     a_i,
  input  logic signed [rpdq_pkg::OpW-1:0]     b_i,
  output rpdq_pkg::mac_res_t                  res_o,
  output logic signed [rpdq_pkg::AccW-1:0]    acc_o
);
  import rpdq_pkg::*;

  localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (FracW - 1);

  mac_op_t                 op_q;
  mac_res_t                res_q;
  logic signed [AccW-1:0]  prod_q;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  acc_d, acc_q;

  always_comb begin
    term  = op_q.rnd ? ((prod_q + Half) >>> FracW) : prod_q;
    acc_d = (op_q.first ? '0 : acc_q) + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      res_q <= '0;
    end else begin
      op_q      <= op_i;
      res_q.valid <= op_q.valid & op_q.last;
      res_q.tag <= op_q.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (op_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign res_o = res_q;
  assign acc_o = acc_q;

endmodule

// ===== hdl/rpdq_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module rpdq_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpdq_pkg::SqW-1:0]      x_i,
  output logic                          done_o,
  output logic [rpdq_pkg::RootW-1:0]    root_o
);
  import rpdq_pkg::*;

  logic           busy_q, done_q;
  logic [SqW-1:0] x_q, r_q, bit_q;
  logic [SqW:0]   trial;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= SqW'(1) << (SqW - 2);
    end else if (busy_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_q <= x_q - trial[SqW-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];

endmodule

// ===== hdl/rpdq_div.sv =====
// Restoring divider for round(mag * 2^30 / n), one quotient bit per cycle.
module rpdq_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpdq_pkg::MagW-1:0]     mag_i,
  input  logic [rpdq_pkg::RootW-1:0]    den_i,
  output logic                          done_o,
  output logic [rpdq_pkg::QuoW-1:0]     quo_o
);
  import rpdq_pkg::*;

  localparam int NumW = MagW + FracW + 1;

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [NumW-1:0]   num;
  logic [RootW-1:0]  den_q, rem_q;
  logic [QuoW-1:0]   low_q, quo_q;
  logic [RootW:0]    rem2;
  logic              fit;

  // Numerator carries the half-divisor for round half up.
  assign num  = {1'b0, mag_i, FracW'(0)} + NumW'(den_i >> 1);
  assign rem2 = {rem_q, low_q[QuoW-1]};
  assign fit  = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QuoW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= RootW'(num[NumW-1:QuoW]);
      low_q <= num[QuoW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? RootW'(rem2 - {1'b0, den_q}) : rem2[RootW-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[QuoW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/relative_pose_delta_quaternion_unit.sv =====
// Top level: relative pose delta with normalised quaternion, sequenced over shared units.
//
//  channel   | direction | tdata fields (lowest bit up)                     | tuser
//  s_axis    | in        | rot_00..rot_22, pos_x, pos_y, pos_z (12 x 32)   | -
//  m_axis    | out       | delta_x/y/z, quat_x/y/z/w (7 x 32)              | norm_error
//
//  Each pose after the first runs from acceptance to result through these steps in order:
//  multiplier beats through the shared multiply-accumulate unit, scaling steps, squaring
//  beats, square-root steps and one division for each of the four quaternion components.
//  A pose with a degenerate branch or a zero norm skips the later steps and ends sooner.
//  The first pose after reset is only stored and gives no beat.
//  s_axis_tready_o is high only while the sequencer idles; a finished beat waits in the
//  output register, and a new pose may be taken meanwhile. Reset is asynchronous, active low,
//  and clears the sequencer and the stored-pose flag; no clearing pass is needed.
module relative_pose_delta_quaternion_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [383:0] s_axis_tdata_i,   // rot_00..rot_22, pos_x, pos_y, pos_z
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [223:0] m_axis_tdata_o,   // delta_x, delta_y, delta_z, quat_x, quat_y, quat_z, quat_w
  output logic [0:0]   m_axis_tuser_o    // norm_error
);
  import rpdq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MWAIT, ST_QSEL, ST_SHIFT, ST_SQ, ST_SQWAIT,
    ST_ROOT, ST_DIVGO, ST_DIV, ST_DONE
  } state_e;

  localparam logic signed [VW-1:0]    One     = VW'(1) <<< FracW;
  localparam logic signed [AccW-1:0]  WordMax = AccW'((64'sd1 <<< (WordW - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0]  WordMin = -WordMax - AccW'(1);

  state_e                    state_q;
  logic                      have_prev_q;
  tag_t                      grp_q;
  logic [1:0]                k_q, qi_q;
  logic                      err_q;
  logic                      m_valid_q;

  logic signed [WordW-1:0]   prev_q [NumIn];
  logic signed [WordW-1:0]   cur_q  [NumIn];
  logic signed [OpW-1:0]     diff_q [3];
  logic signed [DW-1:0]      d_q    [9];
  logic signed [WordW-1:0]   dl_q   [3];
  logic signed [VW-1:0]      v_q    [4];
  logic        [VW-1:0]      mag_q  [4];
  logic signed [WordW-1:0]   quat_q [4];
  logic        [RootW-1:0]   n_q;
  logic        [223:0]       m_data_q;
  logic                      m_err_q;

  logic                      s_hs, m_hs;
  logic signed [WordW-1:0]   in_f [NumIn];
  grp_sel_t                  sel;
  logic [3:0]                idx_a, idx_b;
  mac_op_t                   mac_op;
  logic signed [OpW-1:0]     mac_a, mac_b;
  mac_res_t                  mac_res;
  logic signed [AccW-1:0]    mac_acc;
  logic                      root_start, root_done;
  logic [RootW-1:0]          root;
  logic                      div_start, div_done;
  logic [QuoW-1:0]           quo;
  logic                      big;
  logic                      out_free;

  logic signed [VW-1:0]      e00, e01, e02, e10, e11, e12, e20, e21, e22, trace;
  logic signed [VW-1:0]      nv [4];
  logic signed [VW-1:0]      main_comp;

  function automatic logic signed [WordW-1:0] sat_word(input logic signed [AccW-1:0] x);
    if (x > WordMax) return WordMax[WordW-1:0];
    if (x < WordMin) return WordMin[WordW-1:0];
    return x[WordW-1:0];
  endfunction

  function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] x);
    return x[VW-1] ? VW'(-x) : VW'(x);
  endfunction

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i & s_axis_tready_o;
  assign m_hs            = m_valid_q & m_axis_tready_i;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    for (int f = 0; f < NumIn; f++) begin
      in_f[f] = s_axis_tdata_i[f*WordW +: WordW];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    sel    = grp_sel(grp_q);
    idx_a  = 4'(k_q) * 4'd3 + 4'(sel.row);
    idx_b  = 4'(k_q) * 4'd3 + 4'(sel.col);
    mac_op = '0;
    mac_a  = OpW'(prev_q[idx_a]);
    mac_b  = sel.trans ? diff_q[k_q] : OpW'(cur_q[idx_b]);
    case (state_q)
      ST_MUL: begin
        mac_op.valid = 1'b1;
        mac_op.first = (k_q == 2'd0);
        mac_op.last  = (k_q == 2'd2);
        mac_op.rnd   = 1'b1;
        mac_op.tag   = grp_q;
      end
      ST_SQ: begin
        mac_op.valid = 1'b1;
        mac_op.first = (qi_q == 2'd0);
        mac_op.last  = (qi_q == 2'd3);
        mac_op.tag   = TagSumSq;
        mac_a        = {2'b00, mag_q[qi_q][MagW-1:0]};
        mac_b        = {2'b00, mag_q[qi_q][MagW-1:0]};
      end
      default: mac_op = '0;
    endcase
  end

  // Trace-method branch on the delta rotation.
  always_comb begin
    e00 = VW'(d_q[0]); e01 = VW'(d_q[1]); e02 = VW'(d_q[2]);
    e10 = VW'(d_q[3]); e11 = VW'(d_q[4]); e12 = VW'(d_q[5]);
    e20 = VW'(d_q[6]); e21 = VW'(d_q[7]); e22 = VW'(d_q[8]);
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      nv[3] = trace + One;  nv[0] = e21 - e12;
      nv[1] = e02 - e20;    nv[2] = e10 - e01;
      main_comp = nv[3];
    end else if (e00 > e11 && e00 > e22) begin
      nv[0] = One + e00 - e11 - e22;  nv[3] = e21 - e12;
      nv[1] = e01 + e10;              nv[2] = e02 + e20;
      main_comp = nv[0];
    end else if (e11 > e22) begin
      nv[1] = One + e11 - e00 - e22;  nv[3] = e02 - e20;
      nv[0] = e01 + e10;              nv[2] = e12 + e21;
      main_comp = nv[1];
    end else begin
      nv[2] = One + e22 - e00 - e11;  nv[3] = e10 - e01;
      nv[0] = e02 + e20;              nv[1] = e12 + e21;
      main_comp = nv[2];
    end
  end

  always_comb begin
    big = 1'b0;
    for (int c = 0; c < 4; c++) begin
      big = big | (|mag_q[c][VW-1:MagW]);
    end
  end

  assign root_start = (state_q == ST_SQWAIT) && mac_res.valid && (mac_res.tag == TagSumSq);
  assign div_start  = (state_q == ST_DIVGO);

  rpdq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .res_o  (mac_res),
    .acc_o  (mac_acc)
  );

  rpdq_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .x_i    (mac_acc[SqW-1:0]),
    .done_o (root_done),
    .root_o (root)
  );

  rpdq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (mag_q[qi_q][MagW-1:0]),
    .den_i  (n_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      grp_q       <= '0;
      k_q         <= '0;
      qi_q        <= '0;
      err_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one lands in the same cycle.
      if (m_hs && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            have_prev_q <= 1'b1;
            grp_q       <= '0;
            k_q         <= '0;
            if (have_prev_q) begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (k_q == 2'd2) begin
            k_q   <= '0;
            grp_q <= grp_q + 4'd1;
            if (grp_q == TagLastGroup) begin
              state_q <= ST_MWAIT;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_MWAIT: begin
          if (mac_res.valid && mac_res.tag == TagLastGroup) begin
            state_q <= ST_QSEL;
          end
        end
        ST_QSEL: begin
          err_q   <= (main_comp <= 0);
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!big) begin
            qi_q    <= '0;
            state_q <= err_q ? ST_DONE : ST_SQ;
          end
        end
        ST_SQ: begin
          qi_q <= qi_q + 2'd1;
          if (qi_q == 2'd3) begin
            state_q <= ST_SQWAIT;
          end
        end
        ST_SQWAIT: begin
          if (root_start) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            if (root == '0) begin
              err_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              qi_q    <= '0;
              state_q <= ST_DIVGO;
            end
          end
        end
        ST_DIVGO: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            qi_q <= qi_q + 2'd1;
            state_q <= (qi_q == 2'd3) ? ST_DONE : ST_DIVGO;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      for (int f = 0; f < NumIn; f++) begin
        cur_q[f] <= in_f[f];
        if (!have_prev_q) begin
          prev_q[f] <= in_f[f];
        end
      end
      for (int t = 0; t < 3; t++) begin
        diff_q[t] <= OpW'(in_f[9+t]) - OpW'(prev_q[9+t]);
      end
    end
    // Route each finished sum to its destination.
    if (mac_res.valid) begin
      if (mac_res.tag <= TagRotLast) begin
        d_q[mac_res.tag] <= mac_acc[DW-1:0];
      end else if (mac_res.tag <= TagLastGroup) begin
        dl_q[2'(mac_res.tag - TagTransBase)] <= sat_word(mac_acc);
      end
    end
    case (state_q)
      ST_QSEL: begin
        for (int c = 0; c < 4; c++) begin
          v_q[c]    <= nv[c];
          mag_q[c]  <= abs_v(nv[c]);
          quat_q[c] <= '0;
        end
      end
      ST_SHIFT: begin
        if (big) begin
          for (int c = 0; c < 4; c++) begin
            mag_q[c] <= mag_q[c] >> 1;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          n_q <= root;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          quat_q[qi_q] <= v_q[qi_q][VW-1] ? -WordW'({1'b0, quo}) : WordW'({1'b0, quo});
        end
      end
      ST_DONE: begin
        if (out_free) begin
          for (int f = 0; f < NumIn; f++) begin
            prev_q[f] <= cur_q[f];
          end
          m_data_q <= {err_q ? WordW'(0) : quat_q[3], err_q ? WordW'(0) : quat_q[2],
                       err_q ? WordW'(0) : quat_q[1], err_q ? WordW'(0) : quat_q[0],
                       dl_q[2], dl_q[1], dl_q[0]};
          m_err_q  <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;

  // A flagged beat carries an all-zero quaternion.
  a_err_zero_quat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[223:96] == '0)
    else $error("norm_error beat with non-zero quaternion");

  // Accepting a pose with one already stored starts a run, so the input closes.
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && have_prev_q |=> !s_axis_tready_o)
    else $error("sequencer did not start after a second pose");

  // No accumulator result may arrive while the sequencer idles.
  a_no_stray_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mac_res.valid)
    else $error("accumulator result outside a run");

endmodule
